### src/jsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helpers of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

   localparam int MaxResults = 3;

   localparam logic [2:0] MODE_PLAIN = 3'd0;
   localparam logic [2:0] MODE_ESC   = 3'd1;
   localparam logic [2:0] MODE_HEX1  = 3'd2;
   localparam logic [2:0] MODE_HEX2  = 3'd3;
   localparam logic [2:0] MODE_HEX3  = 3'd4;
   localparam logic [2:0] MODE_HEX4  = 3'd5;

   localparam logic [1:0] KIND_DATA    = 2'd0;
   localparam logic [1:0] KIND_END     = 2'd1;
   localparam logic [1:0] KIND_BAD_ESC = 2'd2;
   localparam logic [1:0] KIND_BAD_HEX = 2'd3;

   localparam logic [7:0] CHR_QUOTE     = 8'h22;
   localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHR_SLASH     = 8'h2F;
   localparam logic [7:0] CHR_B         = 8'h62;
   localparam logic [7:0] CHR_F         = 8'h66;
   localparam logic [7:0] CHR_N         = 8'h6E;
   localparam logic [7:0] CHR_R         = 8'h72;
   localparam logic [7:0] CHR_T         = 8'h74;
   localparam logic [7:0] CHR_U         = 8'h75;
   localparam logic [7:0] CHR_BS        = 8'h08;
   localparam logic [7:0] CHR_FF        = 8'h0C;
   localparam logic [7:0] CHR_LF        = 8'h0A;
   localparam logic [7:0] CHR_CR        = 8'h0D;
   localparam logic [7:0] CHR_TAB       = 8'h09;

   typedef struct packed {
      logic [2:0]       mode;
      logic [11:0]      acc;
      logic [1:0]       count;
      logic [2:0][7:0]  data;
      logic [2:0][1:0]  kind;
   } dec_type;

   // {valid, value}
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39)
         r = {1'b1, 4'(b - 8'h30)};
      else if (b >= 8'h61 && b <= 8'h66)
         r = {1'b1, 4'(b - 8'h57)};
      else if (b >= 8'h41 && b <= 8'h46)
         r = {1'b1, 4'(b - 8'h37)};
      return r;
   endfunction

endpackage

### src/jsu_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_decode
// Decodes one string byte against the current mode: next mode, hex digits
// gathered, and up to three result items.
// ----------------------------------------------------------------------------
module jsu_decode
   import jsu_pkg::*;
(
   input  logic [7:0]  in_byte,
   input  logic [2:0]  mode,
   input  logic [11:0] acc,
   output dec_type     dec
);

   logic [4:0]  hv;
   logic [15:0] cp;

   assign hv = hex_value(in_byte);
   assign cp = {acc, hv[3:0]};

   always_comb begin
      dec.mode  = MODE_PLAIN;
      dec.acc   = acc;
      dec.count = 2'd0;
      dec.data  = '0;
      dec.kind  = {KIND_DATA, KIND_DATA, KIND_DATA};
      unique case (mode) inside
         MODE_ESC: begin
            dec.count = 2'd1;
            case (in_byte)
               CHR_QUOTE:     dec.data[0] = CHR_QUOTE;
               CHR_BACKSLASH: dec.data[0] = CHR_BACKSLASH;
               CHR_SLASH:     dec.data[0] = CHR_SLASH;
               CHR_B:         dec.data[0] = CHR_BS;
               CHR_F:         dec.data[0] = CHR_FF;
               CHR_N:         dec.data[0] = CHR_LF;
               CHR_R:         dec.data[0] = CHR_CR;
               CHR_T:         dec.data[0] = CHR_TAB;
               CHR_U: begin
                  dec.mode  = MODE_HEX1;
                  dec.acc   = 12'd0;
                  dec.count = 2'd0;
               end
               default:       dec.kind[0] = KIND_BAD_ESC;
            endcase
         end
         MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
            if (!hv[4]) begin
               dec.acc     = 12'd0;
               dec.count   = 2'd1;
               dec.kind[0] = KIND_BAD_HEX;
            end else if (mode != MODE_HEX4) begin
               dec.acc  = {acc[7:0], hv[3:0]};
               dec.mode = mode + 3'd1;
            end else begin
               dec.acc = 12'd0;
               if (cp == 16'd0) begin
                  dec.count = 2'd0;
               end else if (cp < 16'd128) begin
                  dec.count   = 2'd1;
                  dec.data[0] = {1'b0, cp[6:0]};
               end else if (cp < 16'd2048) begin
                  dec.count   = 2'd2;
                  dec.data[0] = {3'b110, cp[10:6]};
                  dec.data[1] = {2'b10, cp[5:0]};
               end else begin
                  dec.count   = 2'd3;
                  dec.data[0] = {4'b1110, cp[15:12]};
                  dec.data[1] = {2'b10, cp[11:6]};
                  dec.data[2] = {2'b10, cp[5:0]};
               end
            end
         end
         default: begin
            if (in_byte == CHR_BACKSLASH) begin
               dec.mode = MODE_ESC;
            end else if (in_byte == CHR_QUOTE) begin
               dec.count   = 2'd1;
               dec.kind[0] = KIND_END;
            end else begin
               dec.count   = 2'd1;
               dec.data[0] = in_byte;
            end
         end
      endcase
   end

endmodule

### src/json_string_unescape.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape
// Unescapes a JSON string body byte by byte into UTF-8 output items.
//
//   channel  dir  tdata              tuser          tlast
//   req_     in   [7:0] in_byte      -              -
//   rsp_     out  [7:0] out_byte     [1:0] kind     last_of_run
//
// One input item per cycle; a u escape that yields two or three bytes holds
// req_tready low until its result buffer drains to the last byte.
// Results are registered and appear in the cycle after the input item is taken.
// Synchronous reset clears the decode mode, hex digits and result buffer.
// A stalled rsp_ side holds the buffer and back-pressures req_.
// ----------------------------------------------------------------------------
module json_string_unescape
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [1:0] result_kind
   output logic       rsp_tlast
);

   dec_type          dec;
   logic             load;
   logic             take;

   logic [2:0]       mode_ff, mode_in;
   logic [11:0]      acc_ff, acc_in;
   logic [1:0]       count_ff, count_in;
   logic [2:0][7:0]  data_ff, data_in;
   logic [2:0][1:0]  kind_ff, kind_in;

   jsu_decode u_decode (
      .in_byte (req_tdata),
      .mode    (mode_ff),
      .acc     (acc_ff),
      .dec     (dec)
   );

   assign take       = rsp_tvalid && rsp_tready;
   assign req_tready = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_tready);
   assign load       = req_tvalid && req_tready;

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = data_ff[0];
   assign rsp_tuser  = kind_ff[0];
   assign rsp_tlast  = (count_ff == 2'd1);

   always_comb begin
      mode_in  = mode_ff;
      acc_in   = acc_ff;
      count_in = count_ff;
      data_in  = data_ff;
      kind_in  = kind_ff;
      if (load) begin
         mode_in  = dec.mode;
         acc_in   = dec.acc;
         count_in = dec.count;
         data_in  = dec.data;
         kind_in  = dec.kind;
      end else if (take) begin
         // advance to the next buffered item
         count_in   = count_ff - 2'd1;
         data_in[0] = data_ff[1];
         data_in[1] = data_ff[2];
         kind_in[0] = kind_ff[1];
         kind_in[1] = kind_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_PLAIN;
         acc_ff   <= 12'd0;
         count_ff <= 2'd0;
      end else begin
         mode_ff  <= mode_in;
         acc_ff   <= acc_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      kind_ff <= kind_in;
   end

endmodule
